// File: src/multiclass_perceptron_trainer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multiclass perceptron trainer
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICLASS_PERCEPTRON_TRAINER_ASSERT_SVH
`define MULTICLASS_PERCEPTRON_TRAINER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPT_ASSERT_SAME(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPT_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mpt_pkg.sv
// ----------------------------------------------------------------------------
// mpt_pkg
// Stream field widths, opcodes, the initial weight table and the control
// bundles passed between the trainer's sub-blocks.
// ----------------------------------------------------------------------------
package mpt_pkg;

	// Input request fields, packed from bit 0 upward in tdata.
	localparam int PATTERN_W   = 9;
	localparam int LABEL_W     = 4;
	localparam int RCLASS_W    = 4;
	localparam int RINDEX_W    = 4;
	localparam int IN_TDATA_W  = 24;
	localparam int IN_TUSER_W  = 1;

	localparam int PATTERN_LSB = 0;
	localparam int LABEL_LSB   = PATTERN_LSB + PATTERN_W;
	localparam int RCLASS_LSB  = LABEL_LSB + LABEL_W;
	localparam int RINDEX_LSB  = RCLASS_LSB + RCLASS_W;

	// Result fields, packed from bit 0 upward in tdata.
	localparam int PRED_W      = 4;
	localparam int BEST_W      = 20;
	localparam int TIES_W      = 4;
	localparam int WVAL_W      = 16;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_USED_W  = PRED_W + BEST_W + TIES_W + 1 + WVAL_W;

	typedef enum logic {
		OP_TRAIN = 1'b0,
		OP_READ  = 1'b1
	} opcode_t;

	// Initial weights, indexed by class mod 10 and input mod 9.
	localparam int INIT_ROWS = 10;
	localparam int INIT_COLS = 9;
	localparam logic [3:0] INIT_TABLE [INIT_ROWS][INIT_COLS] = '{
		'{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
		'{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd1},
		'{4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd1, 4'd2},
		'{4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd1, 4'd2, 4'd3},
		'{4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd1, 4'd2, 4'd3, 4'd4},
		'{4'd6, 4'd7, 4'd8, 4'd9, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5},
		'{4'd7, 4'd8, 4'd9, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6},
		'{4'd8, 4'd9, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7},
		'{4'd9, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8},
		'{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9}
	};

	// Weight row memory strobes.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctrl_t;

	// Best-score tracker strobes.
	typedef struct packed {
		logic valid;
		logic first;
	} best_ctrl_t;

endpackage

// File: src/mpt_wmem.sv
// ----------------------------------------------------------------------------
// mpt_wmem
// Weight row memory: one row of all input weights per class, registered read,
// with a valid bit per row so that untouched rows read as the initial table.
// ----------------------------------------------------------------------------
module mpt_wmem #(
	parameter int NUM_CLASSES = 10,
	parameter int NUM_INPUTS  = 9,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mpt_pkg::mem_ctrl_t                    ctrl,
	input  logic [$clog2(NUM_CLASSES)-1:0]        rd_addr,
	input  logic [$clog2(NUM_CLASSES)-1:0]        wr_addr,
	input  logic [NUM_INPUTS*WEIGHT_BITS-1:0]     wr_row,
	output logic [NUM_INPUTS*WEIGHT_BITS-1:0]     rd_row
);
	import mpt_pkg::*;

	localparam int CW    = $clog2(NUM_CLASSES);
	localparam int ROW_W = NUM_INPUTS * WEIGHT_BITS;

	logic [ROW_W-1:0]       mem [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] row_valid_q;
	logic [ROW_W-1:0]       raw_s1;
	logic                   hit_s1;
	logic [CW-1:0]          addr_s1;
	logic [4:0]             addr_ext;
	logic [4:0]             addr_m10;
	logic [ROW_W-1:0]       init_row;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (ctrl.rd_en) begin
			raw_s1  <= mem[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			hit_s1      <= 1'b0;
		end else begin
			if (ctrl.wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				hit_s1 <= row_valid_q[rd_addr];
			end
		end
	end

	// Class index stays below 16, so one conditional subtract gives mod 10.
	assign addr_ext = 5'(addr_s1);
	assign addr_m10 = (addr_ext >= 5'(INIT_ROWS)) ? (addr_ext - 5'(INIT_ROWS)) : addr_ext;

	for (genvar j = 0; j < NUM_INPUTS; j++) begin : g_init
		localparam int COL = j % INIT_COLS;
		assign init_row[j*WEIGHT_BITS +: WEIGHT_BITS] =
			WEIGHT_BITS'(INIT_TABLE[addr_m10[3:0]][COL]);
	end

	assign rd_row = hit_s1 ? raw_s1 : init_row;

endmodule

// File: src/mpt_row_alu.sv
// ----------------------------------------------------------------------------
// mpt_row_alu
// Shared row arithmetic: the masked sum of a weight row for scoring, and the
// saturating step of every masked weight by one for training updates.
// ----------------------------------------------------------------------------
module mpt_row_alu #(
	parameter int NUM_INPUTS  = 9,
	parameter int WEIGHT_BITS = 16
) (
	input  logic [NUM_INPUTS*WEIGHT_BITS-1:0]                   row,
	input  logic [NUM_INPUTS-1:0]                               mask,
	input  logic                                                dec,
	output logic signed [WEIGHT_BITS+$clog2(NUM_INPUTS)-1:0]    sum,
	output logic [NUM_INPUTS*WEIGHT_BITS-1:0]                   new_row
);
	import mpt_pkg::*;

	localparam int SW = WEIGHT_BITS + $clog2(NUM_INPUTS);
	localparam logic [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

	logic signed [WEIGHT_BITS-1:0] w [NUM_INPUTS];
	logic signed [SW-1:0]          acc;

	for (genvar j = 0; j < NUM_INPUTS; j++) begin : g_lane
		assign w[j] = row[j*WEIGHT_BITS +: WEIGHT_BITS];

		always_comb begin
			if (!mask[j]) begin
				new_row[j*WEIGHT_BITS +: WEIGHT_BITS] = w[j];
			end else if (dec) begin
				new_row[j*WEIGHT_BITS +: WEIGHT_BITS] =
					(w[j] == W_MIN) ? w[j] : w[j] - WEIGHT_BITS'(1);
			end else begin
				new_row[j*WEIGHT_BITS +: WEIGHT_BITS] =
					(w[j] == W_MAX) ? w[j] : w[j] + WEIGHT_BITS'(1);
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int j = 0; j < NUM_INPUTS; j++) begin
			if (mask[j]) begin
				acc = acc + SW'(w[j]);
			end
		end
	end

	assign sum = acc;

endmodule

// File: src/mpt_best.sv
// ----------------------------------------------------------------------------
// mpt_best
// Running maximum over class scores: keeps the best score, the lowest class
// that holds it, the number of classes at it and a mask of those classes.
// ----------------------------------------------------------------------------
module mpt_best #(
	parameter int NUM_CLASSES = 10,
	parameter int SCORE_W     = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mpt_pkg::best_ctrl_t                   ctrl,
	input  logic [$clog2(NUM_CLASSES)-1:0]        cls,
	input  logic signed [SCORE_W-1:0]             score,
	output logic signed [SCORE_W-1:0]             best,
	output logic [$clog2(NUM_CLASSES)-1:0]        pred,
	output logic [$clog2(NUM_CLASSES+1)-1:0]      ties,
	output logic [NUM_CLASSES-1:0]                mask
);
	import mpt_pkg::*;

	localparam int CW = $clog2(NUM_CLASSES);
	localparam int TW = $clog2(NUM_CLASSES + 1);

	logic signed [SCORE_W-1:0] best_q;
	logic [CW-1:0]             pred_q;
	logic [TW-1:0]             ties_q;
	logic [NUM_CLASSES-1:0]    mask_q;
	logic [NUM_CLASSES-1:0]    cls_oh;

	assign cls_oh = NUM_CLASSES'(1) << cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			pred_q <= '0;
			ties_q <= '0;
			mask_q <= '0;
		end else if (ctrl.valid) begin
			// Class 0 seeds the maximum, so all-negative scores compare correctly.
			if (ctrl.first || (score > best_q)) begin
				best_q <= score;
				pred_q <= cls;
				ties_q <= TW'(1);
				mask_q <= cls_oh;
			end else if (score == best_q) begin
				ties_q <= ties_q + TW'(1);
				mask_q <= mask_q | cls_oh;
			end
		end
	end

	assign best = best_q;
	assign pred = pred_q;
	assign ties = ties_q;
	assign mask = mask_q;

endmodule

// File: src/multiclass_perceptron_trainer.sv
// ----------------------------------------------------------------------------
// multiclass_perceptron_trainer
// Online winner-take-all perceptron trainer with a readable weight store.
//
//   Channel   Dir   tdata (low bit up)                               tuser
//   s_axis    in    pattern, label, read_class, read_index          opcode
//   m_axis    out   predicted_class, best_score, tie_count,         -
//                   label_among_best, weight_value
//
// A read request goes from idle straight to the done state, where its weight,
// from the registered row read, is loaded into the result register. A training
// request sweeps the score state over all classes, the row memory and the shared
// row unit scoring one class per cycle, then passes the drain and select states;
// each row picked for update is read in UPD_RD and written back in UPD_WR.
// Reset clears per-row valid bits at once; there is no clearing pass.
// s_axis_tready is high only between requests. A result held by a stalled m_axis
// does not block acceptance of the next request, but it holds that request in
// its done cycle until the result register frees up.
// ----------------------------------------------------------------------------
`include "multiclass_perceptron_trainer_assert.svh"

module multiclass_perceptron_trainer #(
	parameter int NUM_CLASSES = 10,
	parameter int NUM_INPUTS  = 9,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pattern[8:0], label[12:9], read_class[16:13], read_index[20:17]
	input  logic [mpt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// opcode[0]
	input  logic [mpt_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// predicted_class[3:0], best_score[23:4], tie_count[27:24],
	// label_among_best[28], weight_value[44:29]
	output logic [mpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import mpt_pkg::*;

	localparam int CW    = $clog2(NUM_CLASSES);
	localparam int IW    = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
	localparam int TW    = $clog2(NUM_CLASSES + 1);
	localparam int SW    = WEIGHT_BITS + $clog2(NUM_INPUTS);
	localparam int ROW_W = NUM_INPUTS * WEIGHT_BITS;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCORE  = 7'b0000010,
		ST_DRAIN  = 7'b0000100,
		ST_SEL    = 7'b0001000,
		ST_UPD_RD = 7'b0010000,
		ST_UPD_WR = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Request fields.
	logic                  accept;
	opcode_t               in_op;
	logic [PATTERN_W-1:0]  in_pattern;
	logic [LABEL_W-1:0]    in_label;
	logic [RCLASS_W-1:0]   in_rclass;
	logic [RINDEX_W-1:0]   in_rindex;
	logic [5:0]            rclass_ext;
	logic [5:0]            rindex_ext;
	logic                  rd_ok;

	opcode_t               op_q;
	logic [NUM_INPUTS-1:0] pat_q;
	logic [LABEL_W-1:0]    label_q;
	logic [IW-1:0]         ridx_q;
	logic                  rd_ok_q;

	// Sequencer.
	logic [CW-1:0]          cls_q;
	logic                   score_v_s1;
	logic [CW-1:0]          score_cls_s1;
	logic [NUM_CLASSES-1:0] upd_mask_q;
	logic [CW-1:0]          upd_cls_q;
	logic [CW-1:0]          upd_first;
	logic                   among_q;

	// Label decode.
	logic [5:0]             label_ext;
	logic                   label_ok;
	logic [CW-1:0]          label_idx;
	logic [NUM_CLASSES-1:0] label_oh;
	logic                   among;

	// Sub-block connections.
	mem_ctrl_t                    mem_ctrl;
	logic [CW-1:0]                mem_rd_addr;
	logic [ROW_W-1:0]             rd_row;
	logic [ROW_W-1:0]             new_row;
	logic signed [SW-1:0]         row_sum;
	logic                         alu_dec;
	best_ctrl_t                   best_ctrl;
	logic signed [SW-1:0]         best_score;
	logic [CW-1:0]                best_pred;
	logic [TW-1:0]                best_ties;
	logic [NUM_CLASSES-1:0]       best_mask;

	// Result assembly.
	logic                         out_load;
	logic signed [WEIGHT_BITS-1:0] wsel;
	logic signed [WEIGHT_BITS+WVAL_W-1:0] wsel_ext;
	logic signed [SW+BEST_W-1:0]  best_ext;
	logic [OUT_USED_W-1:0]        result;
	logic [OUT_TDATA_W-1:0]       out_data_q;
	logic                         out_valid_q;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign in_op      = opcode_t'(s_axis_tuser[0]);
	assign in_pattern = s_axis_tdata[PATTERN_LSB +: PATTERN_W];
	assign in_label   = s_axis_tdata[LABEL_LSB +: LABEL_W];
	assign in_rclass  = s_axis_tdata[RCLASS_LSB +: RCLASS_W];
	assign in_rindex  = s_axis_tdata[RINDEX_LSB +: RINDEX_W];
	assign rclass_ext = 6'(in_rclass);
	assign rindex_ext = 6'(in_rindex);
	assign rd_ok      = (rclass_ext < 6'(NUM_CLASSES)) && (rindex_ext < 6'(NUM_INPUTS));

	assign label_ext = 6'(label_q);
	assign label_ok  = label_ext < 6'(NUM_CLASSES);
	assign label_idx = label_ext[CW-1:0];
	assign label_oh  = label_ok ? (NUM_CLASSES'(1) << label_idx) : '0;
	assign among     = |(best_mask & label_oh);

	// Lowest class still waiting for its row update.
	always_comb begin
		upd_first = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (upd_mask_q[c]) begin
				upd_first = CW'(c);
			end
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_op == OP_READ) ? ST_DONE : ST_SCORE;
				end
			end
			ST_SCORE: begin
				if (cls_q == CW'(NUM_CLASSES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_SEL;
			ST_SEL:    state_d = ST_UPD_RD;
			ST_UPD_RD: state_d = (upd_mask_q == '0) ? ST_DONE : ST_UPD_WR;
			ST_UPD_WR: state_d = ST_UPD_RD;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory read port: class 0 or the read class at acceptance, then the
	// scoring sweep, then the rows picked for update.
	always_comb begin
		mem_ctrl    = '0;
		mem_rd_addr = cls_q;
		case (state_q)
			ST_IDLE: begin
				mem_ctrl.rd_en = accept && ((in_op == OP_TRAIN) || rd_ok);
				mem_rd_addr    = (in_op == OP_READ) ? rclass_ext[CW-1:0] : '0;
			end
			ST_SCORE: begin
				mem_ctrl.rd_en = 1'b1;
				mem_rd_addr    = cls_q;
			end
			ST_UPD_RD: begin
				mem_ctrl.rd_en = (upd_mask_q != '0);
				mem_rd_addr    = upd_first;
			end
			ST_UPD_WR: begin
				mem_ctrl.wr_en = 1'b1;
			end
			default: begin
				mem_ctrl = '0;
			end
		endcase
	end

	// The label row is in the update set only when it gains the pattern.
	assign alu_dec = !(label_ok && (upd_cls_q == label_idx));

	assign best_ctrl.valid = score_v_s1;
	assign best_ctrl.first = (score_cls_s1 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cls_q        <= '0;
			score_v_s1   <= 1'b0;
			score_cls_s1 <= '0;
			upd_mask_q   <= '0;
			upd_cls_q    <= '0;
			among_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			score_v_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_op == OP_TRAIN)) begin
						cls_q        <= CW'(1);
						score_v_s1   <= 1'b1;
						score_cls_s1 <= '0;
					end
				end
				ST_SCORE: begin
					cls_q        <= cls_q + CW'(1);
					score_v_s1   <= 1'b1;
					score_cls_s1 <= cls_q;
				end
				ST_SEL: begin
					among_q    <= among;
					upd_mask_q <= (best_mask & ~label_oh) | (among ? '0 : label_oh);
				end
				ST_UPD_RD: begin
					upd_cls_q <= upd_first;
				end
				ST_UPD_WR: begin
					upd_mask_q[upd_cls_q] <= 1'b0;
				end
				default: begin
					cls_q <= cls_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_op;
			pat_q   <= NUM_INPUTS'(in_pattern);
			label_q <= in_label;
			ridx_q  <= rindex_ext[IW-1:0];
			rd_ok_q <= rd_ok;
		end
	end

	mpt_wmem #(
		.NUM_CLASSES (NUM_CLASSES),
		.NUM_INPUTS  (NUM_INPUTS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_wmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mem_ctrl),
		.rd_addr (mem_rd_addr),
		.wr_addr (upd_cls_q),
		.wr_row  (new_row),
		.rd_row  (rd_row)
	);

	mpt_row_alu #(
		.NUM_INPUTS  (NUM_INPUTS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_row_alu (
		.row     (rd_row),
		.mask    (pat_q),
		.dec     (alu_dec),
		.sum     (row_sum),
		.new_row (new_row)
	);

	mpt_best #(
		.NUM_CLASSES (NUM_CLASSES),
		.SCORE_W     (SW)
	) u_best (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (best_ctrl),
		.cls    (score_cls_s1),
		.score  (row_sum),
		.best   (best_score),
		.pred   (best_pred),
		.ties   (best_ties),
		.mask   (best_mask)
	);

	assign wsel     = rd_row[ridx_q*WEIGHT_BITS +: WEIGHT_BITS];
	assign wsel_ext = (WEIGHT_BITS+WVAL_W)'(wsel);
	assign best_ext = (SW+BEST_W)'(best_score);

	always_comb begin
		if (op_q == OP_READ) begin
			result = {(rd_ok_q ? wsel_ext[WVAL_W-1:0] : WVAL_W'(0)),
				1'b0, TIES_W'(0), BEST_W'(0), PRED_W'(0)};
		end else begin
			result = {WVAL_W'(0), among_q, TIES_W'(best_ties),
				best_ext[BEST_W-1:0], PRED_W'(best_pred)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= OUT_TDATA_W'(result);
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`MPT_ASSERT_NEXT(a_accept_starts_work, accept, state_q != ST_IDLE, "request accepted but sequencer stayed idle")
	`MPT_ASSERT_SAME(a_write_marked_row, mem_ctrl.wr_en, (state_q == ST_UPD_WR) && upd_mask_q[upd_cls_q], "weight row written without being marked for update")
	`MPT_ASSERT_SAME(a_best_has_ties, state_q == ST_SEL, (best_ties != '0) && (best_mask != '0), "score sweep ended with no class at the best score")
	`MPT_ASSERT_SAME(a_result_from_done, $rose(m_axis_tvalid), $past(state_q == ST_DONE), "result became valid outside the done state")

endmodule
